// ===== design/hash_map_put_get_delete_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hash map block
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HASH_MAP_PUT_GET_DELETE_MACROS_SVH
`define HASH_MAP_PUT_GET_DELETE_MACROS_SVH

// Same-cycle implication
`define HMAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define HMAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hmap_pkg.sv =====
// ----------------------------------------------------------------------------
// hmap_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hmap_pkg;

    localparam int KEY_W            = 32;
    localparam int NUM_BUCKETS_DEF  = 1024;
    localparam int SLOTS_DEF        = 4;

    typedef enum logic [1:0] {
        KIND_PUT = 2'd0,
        KIND_GET = 2'd1,
        KIND_DEL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic clear_en;   // write an empty row at the clear pointer
        logic load_in;    // capture input beat, start bucket index
        logic rd_en;      // read bucket row
        logic commit;     // write back row, load result register
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic mod_busy;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/hmap_mod.sv =====
// ----------------------------------------------------------------------------
// hmap_mod
// Bucket index unit: key magnitude modulo the bucket count, by reciprocal
// multiply and a single correction step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmap_mod
    import hmap_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic [KEY_W-1:0]                       i_key,
    output logic                                        o_busy,
    output logic [$clog2(NUM_BUCKETS)-1:0]              o_rem
);

    localparam int BW = $clog2(NUM_BUCKETS);
    // floor(2^32 / NUM_BUCKETS): the quotient estimate is exact or one short
    localparam longint unsigned RECIP_FULL = (64'd1 << KEY_W) / NUM_BUCKETS;
    localparam logic [KEY_W-1:0] RECIP = KEY_W'(RECIP_FULL);
    localparam logic [BW:0] NB = (BW+1)'(NUM_BUCKETS);

    logic [KEY_W-1:0]   r_mag;
    logic [KEY_W-1:0]   r_quo;
    logic [BW-1:0]      r_rem;
    logic               r_busy;
    logic               r_phase;

    logic [2*KEY_W-1:0] prod;
    logic [KEY_W-1:0]   n_quo;
    logic [BW:0]        qnb;
    logic [BW:0]        rough;
    logic [BW:0]        fixed;
    logic [BW-1:0]      n_rem;

    // quotient estimate from the high half of the reciprocal product
    always_comb begin
        prod  = (2*KEY_W)'(r_mag) * (2*KEY_W)'(RECIP);
        n_quo = prod[2*KEY_W-1:KEY_W];
    end

    // remainder lies below twice the bucket count, so the low bits suffice
    always_comb begin
        qnb   = r_quo[BW:0] * NB;
        rough = r_mag[BW:0] - qnb;
        fixed = rough - NB;
        n_rem = (rough >= NB) ? fixed[BW-1:0] : rough[BW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
        end else if (r_busy) begin
            r_phase <= 1'b1;
            if (r_phase) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_key[KEY_W-1] ? (KEY_W'(0) - i_key) : i_key;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_quo <= n_quo;
            end else begin
                r_rem <= n_rem;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== design/hmap_dp.sv =====
// ----------------------------------------------------------------------------
// hmap_dp
// Datapath: input capture, bucket memories, slot match and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmap_dp
    import hmap_pkg::*;
#(
    parameter int NUM_BUCKETS      = NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [1:0]         i_kind,
    input  wire logic [KEY_W-1:0]   i_key,
    input  wire logic [KEY_W-1:0]   i_data_in,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [KEY_W-1:0]        o_data_out
);

    localparam int BW  = $clog2(NUM_BUCKETS);
    localparam int SW  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int EW  = KEY_W + 1;                 // occupied flag + key
    localparam int KRW = SLOTS_PER_BUCKET * EW;
    localparam int VRW = SLOTS_PER_BUCKET * KEY_W;

    logic [KRW-1:0] r_kmem [NUM_BUCKETS];
    logic [VRW-1:0] r_vmem [NUM_BUCKETS];

    t_kind            r_kind;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_data;
    logic [KRW-1:0]   r_krow;
    logic [VRW-1:0]   r_vrow;
    logic [BW-1:0]    r_clr_addr;
    logic [BW-1:0]    bucket;
    logic             mod_busy;

    logic [KRW-1:0]   n_krow;
    logic [VRW-1:0]   n_vrow;
    t_status          n_status;
    logic [KEY_W-1:0] n_dout;

    logic             r_ovalid;
    t_status          r_status;
    logic [KEY_W-1:0] r_dout;

    hmap_mod #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load_in),
        .i_key   (i_key),
        .o_busy  (mod_busy),
        .o_rem   (bucket)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= t_kind'(i_kind);
            r_key  <= i_key;
            r_data <= i_data_in;
        end
    end

    // clear pointer walks every row once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr_addr <= r_clr_addr + BW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_kmem[r_clr_addr] <= '0;
        end else if (i_cmd.commit) begin
            r_kmem[bucket] <= n_krow;
        end
        if (i_cmd.rd_en) begin
            r_krow <= r_kmem[bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_vmem[bucket] <= n_vrow;
        end
        if (i_cmd.rd_en) begin
            r_vrow <= r_vmem[bucket];
        end
    end

    // slot match, lowest free slot and row update
    always_comb begin
        logic [SW-1:0] hit_idx;
        logic [SW-1:0] free_idx;
        logic          have_hit;
        logic          have_free;
        logic [EW-1:0] entry;
        hit_idx   = '0;
        free_idx  = '0;
        have_hit  = 1'b0;
        have_free = 1'b0;
        for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
            entry = r_krow[s*EW +: EW];
            if (entry[KEY_W] && (entry[KEY_W-1:0] == r_key)) begin
                have_hit = 1'b1;
                hit_idx  = SW'(s);
            end
            if (!entry[KEY_W]) begin
                have_free = 1'b1;
                free_idx  = SW'(s);
            end
        end

        n_krow   = r_krow;
        n_vrow   = r_vrow;
        n_status = ST_OK;
        n_dout   = '0;
        case (r_kind)
            KIND_PUT: begin
                if (have_hit) begin
                    n_vrow[hit_idx*KEY_W +: KEY_W] = r_data;
                end else if (have_free) begin
                    n_krow[free_idx*EW +: EW]      = {1'b1, r_key};
                    n_vrow[free_idx*KEY_W +: KEY_W] = r_data;
                end else begin
                    n_status = ST_FULL;
                end
            end
            KIND_GET: begin
                if (have_hit) begin
                    n_dout = r_vrow[hit_idx*KEY_W +: KEY_W];
                end else begin
                    n_status = ST_MISS;
                end
            end
            KIND_DEL: begin
                if (have_hit) begin
                    n_dout = r_vrow[hit_idx*KEY_W +: KEY_W];
                    n_krow[hit_idx*EW +: EW] = '0;
                end else begin
                    n_status = ST_MISS;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_dout   <= n_dout;
        end
    end

    assign o_stat.clear_last = (r_clr_addr == BW'(NUM_BUCKETS - 1));
    assign o_stat.mod_busy   = mod_busy;
    assign o_stat.out_free   = !r_ovalid || !i_stall;

    assign o_valid    = r_ovalid;
    assign o_status   = r_status;
    assign o_data_out = r_dout;

endmodule

`default_nettype wire

// ===== design/hmap_ctrl.sv =====
// ----------------------------------------------------------------------------
// hmap_ctrl
// Controller: clearing pass, then accept, index, read and commit per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hash_map_put_get_delete_macros.svh"

module hmap_ctrl
    import hmap_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_stat   i_stat
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_DECIDE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MOD;
                end
            end
            S_MOD: begin
                if (!i_stat.mod_busy) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // hold until the result register can take the beat
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    `HMAP_ASSERT_NEXT(a_load_starts_index, o_cmd.load_in, (r_state == S_MOD) && i_stat.mod_busy, "index unit not started on accepted beat")
    `HMAP_ASSERT_NEXT(a_read_then_decide, o_cmd.rd_en, r_state == S_DECIDE, "bucket read not followed by decision")
    `HMAP_ASSERT_NOW(a_commit_needs_room, o_cmd.commit, i_stat.out_free && !o_cmd.clear_en, "commit while result register occupied")
    `HMAP_ASSERT_NEXT(a_clear_ends, (r_state == S_CLEAR) && i_stat.clear_last, r_state == S_IDLE, "clearing pass did not finish")

endmodule

`default_nettype wire

// ===== design/hash_map_put_get_delete.sv =====
// Sequence: each accepted beat passes through the reciprocal product, the remainder,
// the row read and the write-back, which waits until the output register is free.
// Flow: o_stall stays high until the write-back, so no new beat is taken before the
// previous one is through; a stalled result holds the next write-back.
// Reset: synchronous; a clearing pass then empties one bucket row a cycle, with
// o_stall held high until it completes.
// ----------------------------------------------------------------------------
// hash_map_put_get_delete
// Hash map of signed 32-bit keys and values with a fixed set of slots per bucket.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hash_map_put_get_delete
    import hmap_pkg::*;
#(
    parameter int NUM_BUCKETS      = NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [31:0] i_key,
    input  wire logic signed [31:0] i_data_in,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_data_out
);

    // Command and status between the controller and the datapath.
    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [KEY_W-1:0] dout;

    // Controller: runs the clearing pass after reset, then sequences each
    // beat through capture, bucket index, row read and write-back.
    hmap_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // Datapath: one bucket row per memory word, so a single read brings in
    // every slot of the bucket; compare all slots, pick the lowest free one,
    // and write the whole row back. The result register lets the next beat
    // be accepted while the previous result is still stalled.
    hmap_dp #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_kind     (i_kind),
        .i_key      (i_key),
        .i_data_in  (i_data_in),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_data_out (dout)
    );

    // Drive the signed result port.
    assign o_data_out = signed'(dout);

endmodule

`default_nettype wire

// ===== dv/tb_hash_map_put_get_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_map_put_get_delete
// Self-checking bench for the bucketed hash map. A shadow copy of the slot
// store predicts the reply to every accepted request beat. Replies are checked
// in order against that prediction. A directed opener covers the corner cases.
// Random traffic then runs over a few hot buckets, under four idle/stall mixes.
// ----------------------------------------------------------------------------

import hmap_pkg::*;

localparam int HM_BUCKETS    = NUM_BUCKETS_DEF;
localparam int HM_SLOTS      = SLOTS_DEF;
localparam int HM_SLOT_TOTAL = HM_BUCKETS * HM_SLOTS;

typedef struct {
    t_status     status;
    logic [31:0] data;
} t_reply;

class hash_shadow;
    bit        occupied [HM_SLOT_TOTAL];
    bit [31:0] slot_key [HM_SLOT_TOTAL];
    bit [31:0] slot_val [HM_SLOT_TOTAL];
    t_reply    due_replies [$];
    int        mismatches;
    int        beats_by_kind [4];
    int        replies_by_status [4];

    // Apply one accepted request to the shadow store and queue its reply.
    function void apply_request(logic [1:0] kind, logic [31:0] key, logic [31:0] data);
        bit [31:0] mag;
        int        base;
        int        hit;
        int        free_slot;
        int        s;
        t_reply    r;
        mag       = key[31] ? 32'd0 - key : key;
        base      = int'(mag % HM_BUCKETS) * HM_SLOTS;
        hit       = -1;
        free_slot = -1;
        for (s = 0; s < HM_SLOTS; s++) begin
            if (occupied[base + s] && slot_key[base + s] == key && hit < 0)
                hit = base + s;
            if (!occupied[base + s] && free_slot < 0)
                free_slot = base + s;
        end
        r.status = ST_OK;
        r.data   = '0;
        beats_by_kind[kind]++;
        case (kind)
            KIND_PUT: begin
                if (hit >= 0) begin
                    slot_val[hit] = data;
                end else if (free_slot >= 0) begin
                    occupied[free_slot] = 1'b1;
                    slot_key[free_slot] = key;
                    slot_val[free_slot] = data;
                end else begin
                    r.status = ST_FULL;
                end
            end
            KIND_GET, KIND_DEL: begin
                if (hit >= 0) begin
                    r.data = slot_val[hit];
                    if (kind == KIND_DEL)
                        occupied[hit] = 1'b0;
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: ;
        endcase
        due_replies = {due_replies, r};
    endfunction

    function void check_reply(logic [1:0] status, logic [31:0] data);
        t_reply want;
        if (due_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected reply beat: status %0d data %h", status, data);
            return;
        end
        want = due_replies.pop_front();
        replies_by_status[int'(want.status)]++;
        if (status !== want.status || data !== want.data) begin
            mismatches++;
            if (mismatches <= 10)
                $display("reply mismatch: status exp %0d got %0d, data exp %h got %h",
                         want.status, status, want.data, data);
        end
    endfunction
endclass

module tb_hash_map_put_get_delete;

    localparam int         LIMIT_CYCLES    = 300000;
    localparam int         DRAIN_CYCLES    = 40;
    localparam int         ITEMS_PER_PHASE = 250;
    // the two-bit kind field has one code the block must treat as a no-op
    localparam logic [1:0] KIND_SPARE      = 2'd3;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic               o_stall;
    logic [1:0]         i_kind    = KIND_PUT;
    logic signed [31:0] i_key     = '0;
    logic signed [31:0] i_data_in = '0;
    logic               o_valid;
    logic               i_stall   = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_data_out;

    // Percentages of cycles in which the request side idles and the reply
    // side stalls; changed per phase.
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned cycle_count = 0;

    // A handful of buckets that take most of the random keys, so that chains
    // fill up, overflow and drain again.
    int unsigned hot_bucket [6] = '{0, 1, 511, 512, 1022, 1023};
    int unsigned idle_plan  [4] = '{0, 73, 0, 29};
    int unsigned stall_plan [4] = '{0, 0, 73, 29};

    hash_shadow sb;

    hash_map_put_get_delete uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_key      (i_key),
        .i_data_in  (i_data_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_data_out (o_data_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost reply ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, sb.due_replies.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Reply side: check the beat taken at this edge, then pick the stall for
    // the next one. i_stall is read before its update lands, so the check sees
    // exactly the value the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_reply(o_status, o_data_out);
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one request beat and hold it until the block takes it. Idle cycles
    // go in front of the beat; valid is only lowered in a step where it is not
    // also raised.
    task automatic send_request(input logic [1:0] kind, input logic [31:0] key,
                                input logic [31:0] data);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_key     <= key;
        i_data_in <= data;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.apply_request(kind, key, data);
    endtask

    // Mostly keys that land in a hot bucket, either sign, with rows up to the
    // top of the positive range; some fully random keys and the most negative
    // key, whose magnitude only fits unsigned.
    function automatic logic [31:0] pick_key();
        int unsigned r;
        int unsigned row;
        int unsigned mag;
        r = $urandom_range(99);
        if (r < 4)
            return 32'h8000_0000;
        if (r < 18)
            return $urandom();
        row = $urandom_range(5);
        if (row == 5)
            row = 32'h7fff_ffff / HM_BUCKETS;
        mag = hot_bucket[$urandom_range(5)] + row * HM_BUCKETS;
        return $urandom_range(1) ? mag : 32'd0 - mag;
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return 32'h7fff_ffff;
        if (r < 16)
            return 32'h8000_0000;
        if (r < 20)
            return 32'h0;
        return $urandom();
    endfunction

    task automatic send_random();
        int unsigned r;
        logic [1:0]  kind;
        r    = $urandom_range(99);
        kind = (r < 42) ? KIND_PUT : (r < 72) ? KIND_GET : (r < 97) ? KIND_DEL : KIND_SPARE;
        send_request(kind, pick_key(), pick_value());
    endtask

    initial begin
        int phase;
        int n;
        sb = new;

        // Hold reset, then release; the block's clearing pass shows up as a
        // long stall on the first beat.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opener, no idling on either side.
        // Misses on an empty map.
        send_request(KIND_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(KIND_DEL, 32'h0000_0000, 32'h0);
        // Fill bucket 0 with keys of both signs, the most negative key among them.
        send_request(KIND_PUT, 32'h0000_0000, 32'h7fff_ffff);
        send_request(KIND_PUT, 32'h8000_0000, 32'h8000_0000);
        send_request(KIND_PUT, 32'h0000_0400, 32'h0000_0001);
        send_request(KIND_PUT, 32'hffff_fc00, 32'hffff_ffff);
        // New key into the full bucket: dropped and flagged.
        send_request(KIND_PUT, 32'h0000_0800, 32'h0000_0063);
        // Existing key in a full bucket: overwrite in place.
        send_request(KIND_PUT, 32'h0000_0000, 32'h0000_0005);
        send_request(KIND_GET, 32'h0000_0000, 32'h0);
        send_request(KIND_GET, 32'h8000_0000, 32'h0);
        // Delete frees a middle slot; the next put must take that slot.
        send_request(KIND_DEL, 32'h0000_0400, 32'h0);
        send_request(KIND_PUT, 32'h0000_0800, 32'h0000_004d);
        send_request(KIND_GET, 32'h0000_0800, 32'h0);
        send_request(KIND_GET, 32'h0000_0400, 32'h0);
        // Largest key and its negation share the top bucket but are distinct.
        send_request(KIND_PUT, 32'h7fff_ffff, 32'h0000_007b);
        send_request(KIND_GET, 32'h8000_0001, 32'h0);
        send_request(KIND_PUT, 32'h8000_0001, 32'h0000_0009);
        send_request(KIND_GET, 32'h7fff_ffff, 32'h0);
        send_request(KIND_GET, 32'h8000_0001, 32'h0);
        // Unused kind: no state change, plain done reply.
        send_request(KIND_SPARE, 32'h0000_0000, 32'hdead_beef);
        send_request(KIND_GET, 32'h0000_0000, 32'h0);
        // Delete hit returns the value, a second delete misses.
        send_request(KIND_DEL, 32'h8000_0000, 32'h0);
        send_request(KIND_DEL, 32'h8000_0000, 32'h0);
        send_request(KIND_PUT, 32'h5555_aaaa, 32'haaaa_5555);
        send_request(KIND_DEL, 32'h5555_aaaa, 32'h0);

        // Random traffic, one idle/stall mix per phase.
        for (phase = 0; phase < 4; phase++) begin
            idle_pct  = idle_plan[phase];
            stall_pct <= stall_plan[phase];
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_random();
        end
        i_valid <= 1'b0;

        // Drain: wait for every queued reply, then idle on to catch stray replies.
        while (sb.due_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Request beats: %0d put, %0d get, %0d delete, %0d unused kind, over %0d mixes",
                 sb.beats_by_kind[KIND_PUT], sb.beats_by_kind[KIND_GET],
                 sb.beats_by_kind[KIND_DEL], sb.beats_by_kind[KIND_SPARE], 4);
        $display("Replies: %0d done/found, %0d not found, %0d full-bucket drops, %0d bad",
                 sb.replies_by_status[ST_OK], sb.replies_by_status[ST_MISS],
                 sb.replies_by_status[ST_FULL], sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/hmap_pkg.sv
design/hmap_mod.sv
design/hmap_dp.sv
design/hmap_ctrl.sv
design/hash_map_put_get_delete.sv
dv/tb_hash_map_put_get_delete.sv
